/* rtl/core/tcau_pkg.sv */
// Shared types, opcodes and constants of the timecode arithmetic unit.
`default_nettype none

package tcau_pkg;

   localparam int STAGES = 6;

   localparam logic [2:0] OP_ADD       = 3'd0;
   localparam logic [2:0] OP_SUB       = 3'd1;
   localparam logic [2:0] OP_TO_TC     = 3'd2;
   localparam logic [2:0] OP_TO_FRAMES = 3'd3;
   localparam logic [2:0] OP_COMPARE   = 3'd4;

   localparam logic [4:0]  FRAMES_PER_SEC = 5'd25;
   localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
   localparam logic [5:0]  MINS_PER_HOUR  = 6'd60;
   localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;

   // floor(2^30 / 25), floor(2^32 / 3600), ceil(2^18 / 60)
   localparam logic [25:0] RECIP_25   = 26'd42949672;
   localparam logic [20:0] RECIP_3600 = 21'd1193046;
   localparam logic [12:0] RECIP_60   = 13'd4370;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  a_hour;
      logic [5:0]  a_minute;
      logic [5:0]  a_second;
      logic [4:0]  a_frame;
      logic [7:0]  b_hour;
      logic [5:0]  b_minute;
      logic [5:0]  b_second;
      logic [4:0]  b_frame;
      logic [24:0] frame_count;
   } req_type;

   typedef struct packed {
      logic [7:0]  res_hour;
      logic [5:0]  res_minute;
      logic [5:0]  res_second;
      logic [4:0]  res_frame;
      logic [24:0] res_total_frames;
      logic        wrapped;
      logic        is_less;
      logic        is_equal;
      logic        is_greater;
   } rsp_type;

   typedef struct packed {
      logic [STAGES-1:0] load;
      logic [STAGES-1:0] valid;
   } flow_type;

endpackage

`default_nettype wire

/* rtl/core/tcau_flow.sv */
// Stage valid bits and load enables of the timecode pipeline.
`default_nettype none

module tcau_flow (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               out_stall,
   output logic               in_stall,
   output tcau_pkg::flow_type flow
);
   import tcau_pkg::*;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   ready;

   // a stage takes a beat when empty or when its successor moves on
   always_comb begin
      ready[STAGES] = !out_stall;
      for (int k = STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ready[0]) begin
         valid_in[0] = in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_stall   = !ready[0];
   assign flow.load  = ready[STAGES-1:0];
   assign flow.valid = valid_ff;

endmodule

`default_nettype wire

/* rtl/core/timecode_arithmetic_unit_top.sv */
// Top level of the 25 fps timecode arithmetic unit.
// Six register stages lie between an accepted req beat and rsp_valid, one
// per constant multiply or digit step. Throughput: one beat per cycle
// when rsp_stall is low; the six stages drain into any gap.
// Reset: synchronous, active high; clears the stage valid bits only.
`default_nettype none

module timecode_arithmetic_unit_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcau_pkg::req_type req_beat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcau_pkg::rsp_type rsp_beat
);
   import tcau_pkg::*;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  a_hour;
      logic [7:0]  b_hour;
      logic [5:0]  a_minute;
      logic [5:0]  b_minute;
      logic [5:0]  a_second;
      logic [4:0]  a_frame;
      logic [24:0] frame_count;
      logic [4:0]  frame;
      logic [5:0]  second;
      logic        carry;
      logic        is_less;
      logic        is_equal;
      logic        is_greater;
      logic [13:0] mins_total;
      logic [20:0] secs_est;
   } stage1_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  frame;
      logic        wrapped;
      logic        is_less;
      logic        is_equal;
      logic        is_greater;
      logic [4:0]  conv_frame;
      logic [7:0]  conv_hour;
      logic [5:0]  conv_minute;
      logic [24:0] total;
   } hold_type;

   tcau_pkg::flow_type flow;

   tcau_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_stall (rsp_stall),
      .in_stall  (req_stall),
      .flow      (flow)
   );

   // stage 1: frame and second digits, compare, first products
   stage1_type  s1_in, s1_ff;
   logic [5:0]  f_sum, f_dif;
   logic [6:0]  s_sum, s_dif;
   logic        f_carry, f_borrow;
   logic [50:0] prod1;

   always_comb begin
      f_sum    = {1'b0, req_beat.a_frame} + {1'b0, req_beat.b_frame};
      f_carry  = f_sum >= {1'b0, FRAMES_PER_SEC};
      f_dif    = {1'b0, req_beat.a_frame} - {1'b0, req_beat.b_frame};
      f_borrow = f_dif[5];
      s_sum    = {1'b0, req_beat.a_second} + {1'b0, req_beat.b_second} + {6'd0, f_carry};
      s_dif    = {1'b0, req_beat.a_second} - {1'b0, req_beat.b_second} - {6'd0, f_borrow};
      prod1    = 51'(req_beat.frame_count) * 51'(RECIP_25);

      s1_in.op          = req_beat.operation;
      s1_in.a_hour      = req_beat.a_hour;
      s1_in.b_hour      = req_beat.b_hour;
      s1_in.a_minute    = req_beat.a_minute;
      s1_in.b_minute    = req_beat.b_minute;
      s1_in.a_second    = req_beat.a_second;
      s1_in.a_frame     = req_beat.a_frame;
      s1_in.frame_count = req_beat.frame_count;
      if (req_beat.operation == OP_SUB) begin
         s1_in.frame  = f_borrow ? 5'(f_dif + {1'b0, FRAMES_PER_SEC}) : f_dif[4:0];
         s1_in.second = s_dif[6] ? 6'(s_dif + {1'b0, SECS_PER_MIN}) : s_dif[5:0];
         s1_in.carry  = s_dif[6];
      end else begin
         s1_in.frame  = f_carry ? 5'(f_sum - {1'b0, FRAMES_PER_SEC}) : f_sum[4:0];
         s1_in.second = (s_sum >= {1'b0, SECS_PER_MIN}) ?
                        6'(s_sum - {1'b0, SECS_PER_MIN}) : s_sum[5:0];
         s1_in.carry  = s_sum >= {1'b0, SECS_PER_MIN};
      end
      s1_in.is_less    = {req_beat.a_hour, req_beat.a_minute, req_beat.a_second,
                          req_beat.a_frame} <
                         {req_beat.b_hour, req_beat.b_minute, req_beat.b_second,
                          req_beat.b_frame};
      s1_in.is_equal   = {req_beat.a_hour, req_beat.a_minute, req_beat.a_second,
                          req_beat.a_frame} ==
                         {req_beat.b_hour, req_beat.b_minute, req_beat.b_second,
                          req_beat.b_frame};
      s1_in.is_greater = {req_beat.a_hour, req_beat.a_minute, req_beat.a_second,
                          req_beat.a_frame} >
                         {req_beat.b_hour, req_beat.b_minute, req_beat.b_second,
                          req_beat.b_frame};
      s1_in.mins_total = 14'(req_beat.a_hour) * 14'(MINS_PER_HOUR) + 14'(req_beat.a_minute);
      s1_in.secs_est   = prod1[50:30];
   end

   // stage 2: minute and hour digits, remainder of the divide by 25
   hold_type    s2_in, s2_ff;
   logic [19:0] s2_secs_total_in, s2_secs_total_ff;
   logic [4:0]  s2_a_frame_ff;
   logic [20:0] s2_secs_in, s2_secs_ff;
   logic [6:0]  m_sum, m_dif;
   logic [8:0]  h_sum, h_dif;
   logic [24:0] f_rem_full;
   logic [5:0]  f_rem;

   always_comb begin
      m_sum      = {1'b0, s1_ff.a_minute} + {1'b0, s1_ff.b_minute} + {6'd0, s1_ff.carry};
      m_dif      = {1'b0, s1_ff.a_minute} - {1'b0, s1_ff.b_minute} - {6'd0, s1_ff.carry};
      f_rem_full = s1_ff.frame_count - 25'(s1_ff.secs_est) * 25'(FRAMES_PER_SEC);
      f_rem      = f_rem_full[5:0];

      s2_in            = '0;
      s2_in.op         = s1_ff.op;
      s2_in.frame      = s1_ff.frame;
      s2_in.second     = s1_ff.second;
      s2_in.is_less    = s1_ff.is_less;
      s2_in.is_equal   = s1_ff.is_equal;
      s2_in.is_greater = s1_ff.is_greater;
      if (s1_ff.op == OP_SUB) begin
         h_sum         = '0;
         h_dif         = {1'b0, s1_ff.a_hour} - {1'b0, s1_ff.b_hour} - {8'd0, m_dif[6]};
         s2_in.minute  = m_dif[6] ? 6'(m_dif + {1'b0, MINS_PER_HOUR}) : m_dif[5:0];
         s2_in.hour    = h_dif[7:0];
         s2_in.wrapped = h_dif[8];
      end else begin
         h_dif         = '0;
         h_sum         = {1'b0, s1_ff.a_hour} + {1'b0, s1_ff.b_hour} +
                         {8'd0, m_sum >= {1'b0, MINS_PER_HOUR}};
         s2_in.minute  = (m_sum >= {1'b0, MINS_PER_HOUR}) ?
                         6'(m_sum - {1'b0, MINS_PER_HOUR}) : m_sum[5:0];
         s2_in.hour    = h_sum[7:0];
         s2_in.wrapped = h_sum[8];
      end
      if (f_rem >= {1'b0, FRAMES_PER_SEC}) begin
         s2_in.conv_frame = 5'(f_rem - {1'b0, FRAMES_PER_SEC});
         s2_secs_in       = s1_ff.secs_est + 21'd1;
      end else begin
         s2_in.conv_frame = f_rem[4:0];
         s2_secs_in       = s1_ff.secs_est;
      end
      s2_secs_total_in = 20'(s1_ff.mins_total) * 20'(SECS_PER_MIN) + 20'(s1_ff.a_second);
   end

   // stage 3: frame total of A, hour estimate of the conversion
   hold_type    s3_in, s3_ff;
   logic [20:0] s3_secs_ff;
   logic [8:0]  s3_hour_est_in, s3_hour_est_ff;
   logic [41:0] prod3;

   always_comb begin
      prod3          = 42'(s2_secs_ff) * 42'(RECIP_3600);
      s3_hour_est_in = prod3[40:32];
      s3_in          = s2_ff;
      s3_in.total    = 25'(s2_secs_total_ff) * 25'(FRAMES_PER_SEC) + 25'(s2_a_frame_ff);
   end

   // stage 4: hour correction and seconds within the hour
   hold_type    s4_in, s4_ff;
   logic [11:0] s4_rem_in, s4_rem_ff;
   logic [20:0] h_rem_full;
   logic [12:0] h_rem;

   always_comb begin
      h_rem_full = s3_secs_ff - 21'(s3_hour_est_ff) * 21'(SECS_PER_HOUR);
      h_rem      = h_rem_full[12:0];
      s4_in      = s3_ff;
      if (h_rem >= {1'b0, SECS_PER_HOUR}) begin
         s4_rem_in       = 12'(h_rem - {1'b0, SECS_PER_HOUR});
         s4_in.conv_hour = 8'(s3_hour_est_ff + 9'd1);
      end else begin
         s4_rem_in       = h_rem[11:0];
         s4_in.conv_hour = s3_hour_est_ff[7:0];
      end
   end

   // stage 5: minutes of the conversion
   hold_type    s5_in, s5_ff;
   logic [11:0] s5_rem_ff;
   logic [24:0] prod5;

   always_comb begin
      prod5             = 25'(s4_rem_ff) * 25'(RECIP_60);
      s5_in             = s4_ff;
      s5_in.conv_minute = prod5[23:18];
   end

   // stage 6: seconds of the conversion, result select
   rsp_type     s6_in, s6_ff;
   logic [11:0] sec_rem;

   always_comb begin
      sec_rem = s5_rem_ff - 12'(s5_ff.conv_minute) * 12'(SECS_PER_MIN);
      s6_in   = '0;
      unique case (s5_ff.op)
         OP_ADD, OP_SUB: begin
            s6_in.res_hour   = s5_ff.hour;
            s6_in.res_minute = s5_ff.minute;
            s6_in.res_second = s5_ff.second;
            s6_in.res_frame  = s5_ff.frame;
            s6_in.wrapped    = s5_ff.wrapped;
         end
         OP_TO_TC: begin
            s6_in.res_hour   = s5_ff.conv_hour;
            s6_in.res_minute = s5_ff.conv_minute;
            s6_in.res_second = sec_rem[5:0];
            s6_in.res_frame  = s5_ff.conv_frame;
         end
         OP_TO_FRAMES: begin
            s6_in.res_total_frames = s5_ff.total;
         end
         OP_COMPARE: begin
            s6_in.is_less    = s5_ff.is_less;
            s6_in.is_equal   = s5_ff.is_equal;
            s6_in.is_greater = s5_ff.is_greater;
         end
         default: begin
            s6_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (flow.load[0]) begin
         s1_ff <= s1_in;
      end
      if (flow.load[1]) begin
         s2_ff            <= s2_in;
         s2_secs_ff       <= s2_secs_in;
         s2_secs_total_ff <= s2_secs_total_in;
         s2_a_frame_ff    <= s1_ff.a_frame;
      end
      if (flow.load[2]) begin
         s3_ff          <= s3_in;
         s3_secs_ff     <= s2_secs_ff;
         s3_hour_est_ff <= s3_hour_est_in;
      end
      if (flow.load[3]) begin
         s4_ff     <= s4_in;
         s4_rem_ff <= s4_rem_in;
      end
      if (flow.load[4]) begin
         s5_ff     <= s5_in;
         s5_rem_ff <= s4_rem_ff;
      end
      if (flow.load[5]) begin
         s6_ff <= s6_in;
      end
   end

   assign rsp_valid = flow.valid[STAGES-1];
   assign rsp_beat  = s6_ff;

`ifndef SYNTHESIS
   // input held off only when every stage is full and the output is stalled
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&flow.valid && rsp_stall))
      else $error("req stalled with a bubble in the pipeline");

   // a beat in the last but one stage reaches the output when not stalled
   a_beat_advances: assert property (@(posedge clock) disable iff (reset)
      (flow.valid[STAGES-2] && !rsp_stall) |=> rsp_valid)
      else $error("beat failed to advance to the output stage");

   // wrap and compare flags come from different operations
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_beat.wrapped &&
                      (rsp_beat.is_less || rsp_beat.is_equal || rsp_beat.is_greater)))
      else $error("wrap and compare flags set in the same beat");
`endif

endmodule

`default_nettype wire
